// ===== design/des_pkg.sv =====
package des_pkg;

  localparam int unsigned Rounds = 16;
  localparam int unsigned Stages = Rounds + 1;

  // Pipeline stage contents: halves of the block, key halves and the direction
  typedef struct packed {
    logic        kind;
    logic [31:0] l;
    logic [31:0] r;
    logic [27:0] c;
    logic [27:0] d;
  } des_stage_t;

  localparam logic [6:0] IpTab [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7};

  localparam logic [6:0] FpTab [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25};

  localparam logic [5:0] ETab [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1};

  localparam logic [5:0] PTab [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25};

  localparam logic [6:0] Pc1Tab [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4};

  localparam logic [5:0] Pc2Tab [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32};

  // Left rotation before each encrypt round
  localparam logic [1:0] EncShift [Rounds] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1};

  // Right rotation before each decrypt round; first round uses the PC1 halves as is
  localparam logic [1:0] DecShift [Rounds] = '{
    2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1};

  localparam logic [3:0] SBox [8][64] = '{
    '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
      4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
      4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
      4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
      4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
      4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
      4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
      4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13},
    '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
      4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10,
      4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
      4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5,
      4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
      4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15,
      4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
      4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9},
    '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
      4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8,
      4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
      4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
      4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
      4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7,
      4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
      4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12},
    '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
      4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15,
      4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
      4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9,
      4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
      4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4,
      4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
      4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14},
    '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
      4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9,
      4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
      4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6,
      4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
      4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14,
      4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
      4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3},
    '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
      4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11,
      4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
      4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8,
      4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
      4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6,
      4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
      4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13},
    '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
      4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1,
      4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
      4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6,
      4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
      4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2,
      4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
      4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12},
    '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
      4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7,
      4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
      4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2,
      4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
      4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8,
      4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
      4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11}};

  // Bit 1 of every table is the MSB of the source word
  function automatic logic [63:0] ip_perm(logic [63:0] x);
    logic [63:0] res;
    for (int i = 0; i < 64; i++) res[63-i] = x[64-int'(IpTab[i])];
    return res;
  endfunction

  function automatic logic [63:0] fp_perm(logic [63:0] x);
    logic [63:0] res;
    for (int i = 0; i < 64; i++) res[63-i] = x[64-int'(FpTab[i])];
    return res;
  endfunction

  function automatic logic [55:0] pc1_perm(logic [63:0] x);
    logic [55:0] res;
    for (int i = 0; i < 56; i++) res[55-i] = x[64-int'(Pc1Tab[i])];
    return res;
  endfunction

  function automatic logic [47:0] pc2_perm(logic [55:0] x);
    logic [47:0] res;
    for (int i = 0; i < 48; i++) res[47-i] = x[56-int'(Pc2Tab[i])];
    return res;
  endfunction

  function automatic logic [27:0] rot_left(logic [27:0] v, logic [1:0] amt);
    logic [27:0] res;
    case (amt)
      2'd1:    res = {v[26:0], v[27]};
      2'd2:    res = {v[25:0], v[27:26]};
      default: res = v;
    endcase
    return res;
  endfunction

  function automatic logic [27:0] rot_right(logic [27:0] v, logic [1:0] amt);
    logic [27:0] res;
    case (amt)
      2'd1:    res = {v[0], v[27:1]};
      2'd2:    res = {v[1:0], v[27:2]};
      default: res = v;
    endcase
    return res;
  endfunction

  // Round function: expansion, subkey mix, S-boxes, P
  function automatic logic [31:0] feistel(logic [31:0] r, logic [47:0] subkey);
    logic [47:0] x;
    logic [5:0]  b;
    logic [31:0] s;
    logic [31:0] res;
    for (int i = 0; i < 48; i++) x[47-i] = r[32-int'(ETab[i])];
    x = x ^ subkey;
    for (int i = 0; i < 8; i++) begin
      b = x[47-6*i -: 6];
      s[31-4*i -: 4] = SBox[i][{b[5], b[0], b[4:1]}];
    end
    for (int i = 0; i < 32; i++) res[31-i] = s[32-int'(PTab[i])];
    return res;
  endfunction

endpackage

// ===== design/des_if.sv =====
// Request channel: one block, key and direction per word
interface des_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] data_in;
  logic [63:0] cipher_key;

  modport source (output valid, kind, data_in, cipher_key, input ready);
  modport sink   (input valid, kind, data_in, cipher_key, output ready);
endinterface

// Result channel: one processed block per word
interface des_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_out;

  modport source (output valid, data_out, input ready);
  modport sink   (input valid, data_out, output ready);
endinterface

// ===== design/des_block_cipher_unit.sv =====
// DES block cipher, one 64-bit block per word, FIPS 46 bit order (bit 1 = MSB).
// req_i carries kind (0 encrypt, 1 decrypt), data_in and cipher_key; the key
// parity bits are ignored. rsp_o returns data_out, one word per request word,
// in request order. Both channels move a word when valid and ready are high.
// Pipeline: an input stage (IP and PC1) and one register stage per round,
// 17 stages in all. The last round stage is the output register.
// An accepted word goes from the input stage through each round stage in turn to data_out.
// Throughput: one block per cycle while rsp_o.ready is high; the key schedule runs alongside the data
// in every stage, so key and direction may change with every word.
// Stall: each stage holds while the next one is full and not moving; a free
// stage still takes new data, so bubbles are squeezed out and req_i.ready
// drops only when all 17 stages are full and rsp_o.ready is low.
// Reset: all stage valid bits clear; in-flight words are dropped and the
// unit is ready to accept a word as soon as reset is released.
module des_block_cipher_unit
  import des_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  des_in_if.sink    req_i,
  des_out_if.source rsp_o
);

  des_stage_t          stage_q [Stages];
  des_stage_t          rnd_out [Rounds];
  des_stage_t          entry;
  logic [Stages-1:0]   valid_q;
  logic [Stages:0]     adv;
  logic [63:0]         blk_ip;
  logic [55:0]         cd_pc1;

  // Stage i loads when empty or when its content moves on
  always_comb begin
    adv[Stages] = rsp_o.ready;
    for (int i = Stages - 1; i >= 0; i--) adv[i] = !valid_q[i] || adv[i+1];
  end

  assign req_i.ready = adv[0];

  // Entry: initial permutation and PC1
  assign blk_ip = ip_perm(req_i.data_in);
  assign cd_pc1 = pc1_perm(req_i.cipher_key);

  always_comb begin
    entry.kind = req_i.kind;
    entry.l    = blk_ip[63:32];
    entry.r    = blk_ip[31:0];
    entry.c    = cd_pc1[55:28];
    entry.d    = cd_pc1[27:0];
  end

  // One round per stage
  for (genvar g = 0; g < Rounds; g++) begin : g_round
    des_round u_round (
      .rnd_i   (4'(g)),
      .stage_i (stage_q[g]),
      .stage_o (rnd_out[g])
    );
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) valid_q[0] <= req_i.valid;
      for (int i = 1; i < Stages; i++) begin
        if (adv[i]) valid_q[i] <= valid_q[i-1];
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (adv[0]) stage_q[0] <= entry;
    for (int i = 1; i < Stages; i++) begin
      if (adv[i]) stage_q[i] <= rnd_out[i-1];
    end
  end

  // Output: undo the last swap, then final permutation
  assign rsp_o.valid    = valid_q[Stages-1];
  assign rsp_o.data_out = fp_perm({stage_q[Stages-1].r, stage_q[Stages-1].l});

  // An accepted word always lands in the entry stage
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> valid_q[0])
    else $error("accepted word missing from entry stage");

  // An empty entry stage never back-pressures the requester
  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[0] |-> req_i.ready)
    else $error("entry stage empty but request not ready");

  // Ready drops only when every stage is full and the output stalls
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (&valid_q && !rsp_o.ready))
    else $error("request stalled with a free stage");

  // A word that moves out of the entry stage shows up in stage one
  a_stage_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[0] && adv[1]) |=> valid_q[1])
    else $error("word lost between entry and first round stage");

endmodule

// ===== design/des_round.sv =====
module des_round
  import des_pkg::*;
(
  input  logic [3:0] rnd_i,
  input  des_stage_t stage_i,
  output des_stage_t stage_o
);

  logic [27:0] c_rot;
  logic [27:0] d_rot;
  logic [47:0] subkey;

  // Key schedule step: left rotation for encrypt, right rotation for decrypt
  always_comb begin
    if (stage_i.kind) begin
      c_rot = rot_right(stage_i.c, DecShift[rnd_i]);
      d_rot = rot_right(stage_i.d, DecShift[rnd_i]);
    end else begin
      c_rot = rot_left(stage_i.c, EncShift[rnd_i]);
      d_rot = rot_left(stage_i.d, EncShift[rnd_i]);
    end
  end

  assign subkey = pc2_perm({c_rot, d_rot});

  // Feistel swap
  always_comb begin
    stage_o.kind = stage_i.kind;
    stage_o.l    = stage_i.r;
    stage_o.r    = stage_i.l ^ feistel(stage_i.r, subkey);
    stage_o.c    = c_rot;
    stage_o.d    = d_rot;
  end

endmodule

// ===== tb/sv/tb_des_block_cipher_unit.sv =====
`timescale 1ns / 100ps

module tb_des_block_cipher_unit;

  import des_pkg::*;

  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  localparam int CycleLimit    = 200000;
  localparam int DrainCycles   = 40;
  localparam int WordsPerPhase = 138;
  localparam int NumPhases     = 4;
  localparam int MaxPrinted    = 100;

  // Idle and stall odds (percent) per phase
  localparam int SendIdlePct  [NumPhases] = '{0, 70, 0, 34};
  localparam int RecvStallPct [NumPhases] = '{0, 0, 70, 34};

  // FIPS 46 tables, bit 1 is the MSB of the source word
  localparam int IpOrder [64] = '{
    58, 50, 42, 34, 26, 18, 10, 2, 60, 52, 44, 36, 28, 20, 12, 4,
    62, 54, 46, 38, 30, 22, 14, 6, 64, 56, 48, 40, 32, 24, 16, 8,
    57, 49, 41, 33, 25, 17, 9,  1, 59, 51, 43, 35, 27, 19, 11, 3,
    61, 53, 45, 37, 29, 21, 13, 5, 63, 55, 47, 39, 31, 23, 15, 7};

  localparam int FpOrder [64] = '{
    40, 8, 48, 16, 56, 24, 64, 32, 39, 7, 47, 15, 55, 23, 63, 31,
    38, 6, 46, 14, 54, 22, 62, 30, 37, 5, 45, 13, 53, 21, 61, 29,
    36, 4, 44, 12, 52, 20, 60, 28, 35, 3, 43, 11, 51, 19, 59, 27,
    34, 2, 42, 10, 50, 18, 58, 26, 33, 1, 41, 9,  49, 17, 57, 25};

  localparam int ExpOrder [48] = '{
    32, 1,  2,  3,  4,  5,  4,  5,  6,  7,  8,  9,  8,  9,  10, 11,
    12, 13, 12, 13, 14, 15, 16, 17, 16, 17, 18, 19, 20, 21, 20, 21,
    22, 23, 24, 25, 24, 25, 26, 27, 28, 29, 28, 29, 30, 31, 32, 1};

  localparam int POrder [32] = '{
    16, 7, 20, 21, 29, 12, 28, 17, 1,  15, 23, 26, 5,  18, 31, 10,
    2,  8, 24, 14, 32, 27, 3,  9,  19, 13, 30, 6,  22, 11, 4,  25};

  localparam int Pc1Order [56] = '{
    57, 49, 41, 33, 25, 17, 9,  1,  58, 50, 42, 34, 26, 18,
    10, 2,  59, 51, 43, 35, 27, 19, 11, 3,  60, 52, 44, 36,
    63, 55, 47, 39, 31, 23, 15, 7,  62, 54, 46, 38, 30, 22,
    14, 6,  61, 53, 45, 37, 29, 21, 13, 5,  28, 20, 12, 4};

  localparam int Pc2Order [48] = '{
    14, 17, 11, 24, 1,  5,  3,  28, 15, 6,  21, 10, 23, 19, 12, 4,
    26, 8,  16, 7,  27, 20, 13, 2,  41, 52, 31, 37, 47, 55, 30, 40,
    51, 45, 33, 48, 44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32};

  localparam int KeyShift [16] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

  // S-boxes, one nibble per entry, entry 0 in the top nibble, rows of 16
  localparam logic [255:0] SboxRows [8] = '{
    256'hE4D12FB83A6C5907_0F74E2D1A6CB9538_41E8D62BFC973A50_FC8249175B3EA06D,
    256'hF18E6B34972DC05A_3D47F28EC01A69B5_0E7BA4D158C6932F_D8A13F42B67C05E9,
    256'hA09E63F51DC7B428_D709346A285ECBF1_D6498F30B12C5AE7_1AD069874FE3B52C,
    256'h7DE3069A1285BC4F_D8B56F03472C1AE9_A690CB7DF13E5284_3F06A1D8945BC72E,
    256'h2C417AB6853FD0E9_EB2C47D150FA3986_421BAD78F9C5630E_B8C71E2D6F09A453,
    256'hC1AF92680D34E75B_AF427C9561DE0B38_9EF528C3704A1DB6_432C95FABE17608D,
    256'h4B2EF08D3C975A61_D0B7491AE35C2F86_14BDC37EAF680592_6BD814A7950FE23C,
    256'hD2846FB1A93E50C7_1FD8A374C56B0E92_7B419CE206ADF358_21E74A8DFC90356B};

  typedef struct packed {
    logic        op;
    logic [63:0] blk;
    logic [63:0] key;
    logic        known;
    logic [63:0] want;
  } vector_t;

  // Directed words; a typed-in result only for published vectors
  vector_t directed_vectors [19] = '{
    '{OpEncrypt, 64'h0123456789ABCDEF, 64'h133457799BBCDFF1, 1'b1, 64'h85E813540F0AB405},
    '{OpDecrypt, 64'h85E813540F0AB405, 64'h133457799BBCDFF1, 1'b1, 64'h0123456789ABCDEF},
    '{OpEncrypt, 64'h8787878787878787, 64'h0E329232EA6D0D73, 1'b1, 64'h0000000000000000},
    '{OpDecrypt, 64'h0000000000000000, 64'h0E329232EA6D0D73, 1'b1, 64'h8787878787878787},
    '{OpEncrypt, 64'h0000000000000000, 64'h0000000000000000, 1'b1, 64'h8CA64DE9C1B123A7},
    // weak key: decrypt equals encrypt
    '{OpDecrypt, 64'h0000000000000000, 64'h0000000000000000, 1'b1, 64'h8CA64DE9C1B123A7},
    '{OpDecrypt, 64'h8CA64DE9C1B123A7, 64'h0000000000000000, 1'b1, 64'h0000000000000000},
    '{OpEncrypt, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b1, 64'h7359B2163E4EDC58},
    '{OpDecrypt, 64'h7359B2163E4EDC58, 64'hFFFFFFFFFFFFFFFF, 1'b1, 64'hFFFFFFFFFFFFFFFF},
    // parity bits only differ from the keys above
    '{OpEncrypt, 64'h0000000000000000, 64'h0101010101010101, 1'b1, 64'h8CA64DE9C1B123A7},
    '{OpEncrypt, 64'hFFFFFFFFFFFFFFFF, 64'hFEFEFEFEFEFEFEFE, 1'b1, 64'h7359B2163E4EDC58},
    '{OpEncrypt, 64'h0123456789ABCDEF, 64'h123457799BBCDFF0, 1'b1, 64'h85E813540F0AB405},
    '{OpEncrypt, 64'h8000000000000000, 64'h0101010101010101, 1'b1, 64'h95F8A5E5DD31D900},
    '{OpEncrypt, 64'h0000000000000000, 64'hFFFFFFFFFFFFFFFF, 1'b0, 64'h0},
    '{OpEncrypt, 64'hFFFFFFFFFFFFFFFF, 64'h0000000000000000, 1'b0, 64'h0},
    // weak and semi-weak keys go through like any other
    '{OpEncrypt, 64'h0123456789ABCDEF, 64'h1F1F1F1F0E0E0E0E, 1'b0, 64'h0},
    '{OpEncrypt, 64'h0123456789ABCDEF, 64'h01FE01FE01FE01FE, 1'b0, 64'h0},
    '{OpDecrypt, 64'h0123456789ABCDEF, 64'hE0FEE0FEF1FEF1FE, 1'b0, 64'h0},
    '{OpDecrypt, 64'h0000000000000001, 64'h133457799BBCDFF1, 1'b0, 64'h0}};

  logic clk_i;
  logic rst_ni;

  des_in_if  req_if ();
  des_out_if rsp_if ();

  des_block_cipher_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic [63:0] expected_blocks [$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          cycle_count    = 0;

  // Full DES on one block: key schedule, IP, 16 rounds, FP
  function automatic logic [63:0] des_transform(input logic op, input logic [63:0] blk,
                                                input logic [63:0] key);
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    logic [47:0] subkey [16];
    logic [63:0] perm;
    logic [63:0] swapped;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] sbox_out;
    logic [31:0] f;
    logic [31:0] t;
    logic [47:0] x;
    logic [5:0]  b;
    int          idx;
    for (int i = 0; i < 56; i++) cd[55-i] = key[64-Pc1Order[i]];
    c = cd[55:28];
    d = cd[27:0];
    for (int n = 0; n < 16; n++) begin
      c  = (c << KeyShift[n]) | (c >> (28 - KeyShift[n]));
      d  = (d << KeyShift[n]) | (d >> (28 - KeyShift[n]));
      cd = {c, d};
      for (int j = 0; j < 48; j++) subkey[n][47-j] = cd[56-Pc2Order[j]];
    end
    for (int i = 0; i < 64; i++) perm[63-i] = blk[64-IpOrder[i]];
    l = perm[63:32];
    r = perm[31:0];
    for (int n = 0; n < 16; n++) begin
      for (int j = 0; j < 48; j++) x[47-j] = r[32-ExpOrder[j]];
      x = x ^ ((op == OpDecrypt) ? subkey[15-n] : subkey[n]);
      for (int g = 0; g < 8; g++) begin
        b   = x[47-6*g -: 6];
        idx = int'({b[5], b[0], b[4:1]});
        sbox_out[31-4*g -: 4] = SboxRows[g][255-4*idx -: 4];
      end
      for (int j = 0; j < 32; j++) f[31-j] = sbox_out[32-POrder[j]];
      t = l ^ f;
      l = r;
      r = t;
    end
    swapped = {r, l};
    for (int i = 0; i < 64; i++) perm[63-i] = swapped[64-FpOrder[i]];
    return perm;
  endfunction

  // Mostly random words, some all-zero, all-one and walking-bit patterns
  function automatic logic [63:0] pick_pattern();
    logic [63:0] one_hot;
    one_hot = 64'h1 << $urandom_range(63);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return one_hot;
      3:       return ~one_hot;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < MaxPrinted)
      $display("[%0t] %s: data_out %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Drive one request word and record its expected block once taken
  task automatic send_block(input logic op, input logic [63:0] blk, input logic [63:0] key,
                            input logic known, input logic [63:0] want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.kind       <= op;
    req_if.data_in    <= blk;
    req_if.cipher_key <= key;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    expected_blocks.push_back(known ? want : des_transform(op, blk, key));
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random back-pressure and in-order compare
  initial begin
    logic [63:0] want;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch("word with no block pending", rsp_if.data_out, '0);
        end else begin
          want = expected_blocks.pop_front();
          if (rsp_if.data_out !== want)
            report_mismatch("data_out mismatch", rsp_if.data_out, want);
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus
  initial begin
    logic        op;
    logic [63:0] blk;
    logic [63:0] key;
    logic [63:0] last_cipher;
    logic [63:0] last_key;
    bit          have_prev;
    have_prev          = 1'b0;
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.kind       <= OpEncrypt;
    req_if.data_in    <= '0;
    req_if.cipher_key <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words, no idling
    foreach (directed_vectors[i])
      send_block(directed_vectors[i].op, directed_vectors[i].blk, directed_vectors[i].key,
                 directed_vectors[i].known, directed_vectors[i].want);

    // random words, one idle pattern per phase
    for (int p = 0; p < NumPhases; p++) begin
      send_idle_pct  = SendIdlePct[p];
      recv_stall_pct = RecvStallPct[p];
      for (int i = 0; i < WordsPerPhase; i++) begin
        // now and then decrypt the last ciphertext with its key
        if (have_prev && $urandom_range(3) == 0) begin
          op  = OpDecrypt;
          blk = last_cipher;
          key = last_key;
        end else begin
          op  = 1'($urandom_range(1));
          blk = pick_pattern();
          key = pick_pattern();
        end
        send_block(op, blk, key, 1'b0, '0);
        if (op == OpEncrypt) begin
          last_cipher = des_transform(op, blk, key);
          last_key    = key;
          have_prev   = 1'b1;
        end
      end
    end
    req_if.valid <= 1'b0;

    // drain the pipeline, then watch for stray words
    while (expected_blocks.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
